FILE: rtl/mtm_pkg.sv
// Package for the MUS-to-MIDI event converter: phase and kind codes,
// the parser-to-pipeline struct, and the controller remap tables.
// No dependencies.
`default_nettype none

package mtm_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W = $clog2(CHANNELS);

  localparam logic [3:0] CH_PERC_MUS = 4'hF;
  localparam logic [3:0] CH_PERC_MIDI = 4'h9;

  localparam logic [7:0] SYS_FIRST = 8'd10;
  localparam logic [7:0] SYS_LAST = 8'd14;
  localparam logic [7:0] CTL_PROGRAM = 8'd0;
  localparam logic [7:0] CTL_LAST = 8'd9;

  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON = 4'h9;
  localparam logic [3:0] ST_CONTROL = 4'hB;
  localparam logic [3:0] ST_PROGRAM = 4'hC;
  localparam logic [3:0] ST_BEND = 4'hE;

  localparam logic [31:0] RATE_RESET = 32'd20643840;

  typedef enum logic [2:0] {
    PH_DESC   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_SECOND = 3'd2,
    PH_DELAY  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MIDI  = 2'd0,
    KIND_DELAY = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    EV_NOTE_OFF = 3'd0,
    EV_NOTE_ON  = 3'd1,
    EV_BEND     = 3'd2,
    EV_SYSTEM   = 3'd3,
    EV_CONTROL  = 3'd4,
    EV_MEASURE  = 3'd5,
    EV_END      = 3'd6,
    EV_UNUSED   = 3'd7
  } ev_type_t;

  typedef struct packed {
    logic        hit;
    kind_t       kind;
    logic [7:0]  status;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [31:0] ticks;
  } parse_out_t;

  // System event code (10..14) to MIDI channel-mode controller.
  function automatic logic [7:0] sys_ctrl(input logic [7:0] code);
    logic [7:0] r;
    case (code)
      8'd10:   r = 8'd120;
      8'd11:   r = 8'd123;
      8'd12:   r = 8'd126;
      8'd13:   r = 8'd127;
      8'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // MUS controller number (1..9) to MIDI controller.
  function automatic logic [7:0] ctl_map(input logic [7:0] code);
    logic [7:0] r;
    case (code)
      8'd1:    r = 8'd0;
      8'd2:    r = 8'd1;
      8'd3:    r = 8'd7;
      8'd4:    r = 8'd10;
      8'd5:    r = 8'd11;
      8'd6:    r = 8'd91;
      8'd7:    r = 8'd93;
      8'd8:    r = 8'd64;
      8'd9:    r = 8'd67;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Swap MUS percussion channel 15 with MIDI percussion channel 9.
  function automatic logic [7:0] swap_channel(input logic [7:0] d);
    logic [7:0] r;
    r = d;
    if (d[3:0] == CH_PERC_MUS) begin
      r = {d[7:4], CH_PERC_MIDI};
    end else if (d[3:0] == CH_PERC_MIDI) begin
      r = {d[7:4], CH_PERC_MUS};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mtm_byte_if.sv
// Song byte channel: valid/ready handshake with one 8-bit payload.
// No dependencies.
`default_nettype none

interface mtm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] song_byte;

  modport source (output valid, output song_byte, input ready);
  modport sink (input valid, input song_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/mtm_cfg_if.sv
// Configuration write channel: valid/ready with the samples_per_tick word.
// No dependencies.
`default_nettype none

interface mtm_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] samples_per_tick;

  modport source (output valid, output samples_per_tick, input ready);
  modport sink (input valid, input samples_per_tick, output ready);
endinterface

`default_nettype wire

FILE: rtl/mtm_event_if.sv
// Result channel: valid/ready with the MIDI event / delay / end payload.
// No dependencies.
`default_nettype none

interface mtm_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  midi_status;
  logic [7:0]  midi_first;
  logic [7:0]  midi_second;
  logic [31:0] delay_samples;

  modport source (output valid, output result_kind, output midi_status,
                  output midi_first, output midi_second, output delay_samples,
                  input ready);
  modport sink (input valid, input result_kind, input midi_status,
                input midi_first, input midi_second, input delay_samples,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/mus_to_midi_event_converter_core.sv
// MUS-to-MIDI event converter, top level.
// Throughput: one song byte per cycle unless a stalled result port backs up
//   both stages; the 32x32 tick-times-rate multiply has its own stage so no
//   path holds more than one multiply or one add. A result passes through
//   stage A and then the stage B output register before it is on the result port.
// Reset (rst, synchronous): parser to descriptor phase, channel volumes,
//   tick count and sample fraction to zero, rate to 315.0 (Q16.16), pipeline empty.
`default_nettype none

module mus_to_midi_event_converter_core
  import mtm_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  mtm_byte_if.sink    song,
  mtm_cfg_if.sink     cfg,
  mtm_event_if.source result
);

  // rate register, to be written between songs; the block does not enforce this
  logic [31:0] rate;

  // pipeline: parse -> stage A (product) -> stage B (output register)
  logic       take;
  logic       en_a, en_b;
  parse_out_t pout;

  logic       a_valid;
  kind_t      a_kind;
  logic [7:0] a_status, a_first, a_second;

  logic        b_valid;
  kind_t       b_kind;
  logic [7:0]  b_status, b_first, b_second;
  logic [31:0] b_delay;

  logic [31:0] whole;
  logic        commit;

  // Stage B frees when empty or its beat leaves; stage A frees when empty
  // or moving on, so a new byte goes in while a result waits on the port.
  assign en_b       = !b_valid || result.ready;
  assign en_a       = !a_valid || en_b;
  assign song.ready = en_a;
  assign take       = song.valid && en_a;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_RESET;
    end else if (cfg.valid) begin
      rate <= cfg.samples_per_tick;
    end
  end

  mtm_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .song_byte (song.song_byte),
    .pout      (pout)
  );

  // The fraction is committed as a delay moves into stage B; the next
  // delay is at least two beats behind, so it always sees the new value.
  assign commit = en_b && a_valid && (a_kind == KIND_DELAY);

  mtm_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .load   (en_a),
    .ticks  (pout.ticks),
    .rate   (rate),
    .commit (commit),
    .whole  (whole)
  );

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= take && pout.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_kind   <= pout.kind;
      a_status <= pout.status;
      a_first  <= pout.first;
      a_second <= pout.second;
    end
  end

  // stage B: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_kind   <= a_kind;
      b_status <= a_status;
      b_first  <= a_first;
      b_second <= a_second;
      b_delay  <= (a_kind == KIND_DELAY) ? whole : '0;
    end
  end

  assign result.valid         = b_valid;
  assign result.result_kind   = b_kind;
  assign result.midi_status   = b_status;
  assign result.midi_first    = b_first;
  assign result.midi_second   = b_second;
  assign result.delay_samples = b_delay;

`ifndef ASSERT_OFF
  // a delay beat carries no MIDI bytes
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_DELAY) |->
      (result.midi_status == '0) && (result.midi_first == '0) &&
      (result.midi_second == '0))
    else $error("delay result with MIDI bytes");

  // an end marker carries nothing at all
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.result_kind == KIND_END) |->
      (result.delay_samples == '0) && (result.midi_status == '0))
    else $error("end result with payload");

  // a stalled output stage holds off new bytes and keeps both stages filled
  assert property (@(posedge clk) disable iff (rst)
    a_valid && b_valid && !result.ready |-> !song.ready ##1 (a_valid && b_valid))
    else $error("stage A lost under stall");
`endif

endmodule

`default_nettype wire

FILE: rtl/mtm_parse.sv
// MUS byte parser: descriptor/data/delay state machine and channel volumes.
// Depends on mtm_pkg.
`default_nettype none

module mtm_parse
  import mtm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] song_byte,
  output parse_out_t      pout
);

  phase_t      phase, phase_next;
  logic [7:0]  desc, desc_next;
  logic [7:0]  first_data, first_next;
  logic [31:0] ticks, ticks_next;
  logic [7:0]  vol [CHANNELS];
  logic        vol_we;

  logic [7:0]  swapped;
  logic [CH_W-1:0] ch;
  ev_type_t    cur_type, new_type;
  logic [31:0] ticks_shift;
  phase_t      after_phase;

  assign swapped     = swap_channel(song_byte);
  assign ch          = desc[CH_W-1:0];
  assign cur_type    = ev_type_t'(desc[6:4]);
  assign new_type    = ev_type_t'(swapped[6:4]);
  assign ticks_shift = {ticks[24:0], song_byte[6:0]};
  assign after_phase = desc[7] ? PH_DELAY : PH_DESC;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DESC;
      desc       <= '0;
      first_data <= '0;
      ticks      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        vol[i] <= '0;
      end
    end else if (take) begin
      phase      <= phase_next;
      desc       <= desc_next;
      first_data <= first_next;
      ticks      <= ticks_next;
      if (vol_we) begin
        vol[ch] <= song_byte;
      end
    end
  end

  always_comb begin
    phase_next  = phase;
    desc_next   = desc;
    first_next  = first_data;
    ticks_next  = ticks;
    vol_we      = 1'b0;
    pout        = '0;
    pout.kind   = KIND_MIDI;

    case (phase)
      PH_DESC: begin
        desc_next = swapped;
        if (new_type == EV_END) begin
          pout.hit   = 1'b1;
          pout.kind  = KIND_END;
          phase_next = PH_DONE;
        end else if (new_type == EV_MEASURE || new_type == EV_UNUSED) begin
          phase_next = swapped[7] ? PH_DELAY : PH_DESC;
          ticks_next = '0;
        end else begin
          phase_next = PH_FIRST;
        end
      end
      PH_FIRST: begin
        phase_next = after_phase;
        ticks_next = '0;
        case (cur_type)
          EV_NOTE_OFF: begin
            pout.hit    = 1'b1;
            pout.status = {ST_NOTE_OFF, desc[3:0]};
            pout.first  = song_byte;
          end
          EV_NOTE_ON: begin
            if (song_byte[7]) begin
              first_next = song_byte;
              phase_next = PH_SECOND;
              ticks_next = ticks;
            end else begin
              pout.hit    = 1'b1;
              pout.status = {ST_NOTE_ON, desc[3:0]};
              pout.first  = song_byte;
              pout.second = vol[ch];
            end
          end
          EV_BEND: begin
            pout.hit    = 1'b1;
            pout.status = {ST_BEND, desc[3:0]};
            pout.first  = {1'b0, song_byte[0], 6'd0};
            pout.second = {1'b0, song_byte[7:1]};
          end
          EV_SYSTEM: begin
            if (song_byte inside {[SYS_FIRST:SYS_LAST]}) begin
              pout.hit    = 1'b1;
              pout.status = {ST_CONTROL, desc[3:0]};
              pout.first  = sys_ctrl(song_byte);
            end
          end
          default: begin
            // controller: number now, value in the next beat
            first_next = song_byte;
            phase_next = PH_SECOND;
            ticks_next = ticks;
          end
        endcase
      end
      PH_SECOND: begin
        phase_next = after_phase;
        ticks_next = '0;
        if (cur_type == EV_NOTE_ON) begin
          vol_we      = 1'b1;
          pout.hit    = 1'b1;
          pout.status = {ST_NOTE_ON, desc[3:0]};
          pout.first  = {1'b0, first_data[6:0]};
          pout.second = song_byte;
        end else if (first_data == CTL_PROGRAM) begin
          pout.hit    = 1'b1;
          pout.status = {ST_PROGRAM, desc[3:0]};
          pout.first  = song_byte;
        end else if (first_data <= CTL_LAST) begin
          pout.hit    = 1'b1;
          pout.status = {ST_CONTROL, desc[3:0]};
          pout.first  = ctl_map(first_data);
          pout.second = song_byte;
        end
      end
      PH_DELAY: begin
        if (song_byte[7]) begin
          ticks_next = ticks_shift;
        end else begin
          pout.hit   = 1'b1;
          pout.kind  = KIND_DELAY;
          pout.ticks = ticks_shift;
          ticks_next = '0;
          phase_next = PH_DESC;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DESC;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/mtm_scale.sv
// Tick-to-sample scaler: registered 32x32 product, then add of the carried
// 16-bit fraction with saturation of the whole part. Depends on mtm_pkg.
`default_nettype none

module mtm_scale
  import mtm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [31:0] ticks,
  input  wire logic [31:0] rate,
  input  wire logic        commit,
  output logic [31:0]      whole
);

  logic [63:0] prod;
  logic [15:0] fraction;
  logic [63:0] total;

  // product of two 32-bit values plus 16 bits never carries out of 64 bits
  assign total = prod + {48'd0, fraction};
  assign whole = (total[63:48] != '0) ? '1 : total[47:16];

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= {32'd0, ticks} * {32'd0, rate};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction <= '0;
    end else if (commit) begin
      fraction <= total[15:0];
    end
  end

endmodule

`default_nettype wire
